// ----- rtl/core/imdf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ICY metadata deframer package
// Shared types and constants: the result kinds and the command word that
// travels from the classifier through the queue to the result sequencer.
// ----------------------------------------------------------------------------
package imdf_pkg;

    localparam int TITLE_PREFIX_SKIP_DEF = 11;
    localparam int MAX_PARSE_BLOCK_DEF   = 512;

    localparam int INTERVAL_W  = 20;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        K_AUDIO   = 3'd0,
        K_TITLE   = 3'd1,
        K_DONE    = 3'd2,
        K_SHORT   = 3'd3,
        K_OVERLAP = 3'd4
    } t_kind;

    // One or two results caused by a single input byte.
    typedef struct packed {
        logic       has1;
        t_kind      kind1;
        logic [7:0] byte1;
        t_kind      kind0;
        logic [7:0] byte0;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

endpackage
`default_nettype wire

// ----- rtl/core/imdf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ICY metadata deframer front end
// Accepts stream bytes, tracks the audio/metadata framing, parses the title
// out of short metadata blocks and issues one command per byte that has
// results.
// ----------------------------------------------------------------------------
module imdf_front
    import imdf_pkg::*;
#(
    parameter int TITLE_PREFIX_SKIP = TITLE_PREFIX_SKIP_DEF,
    parameter int MAX_PARSE_BLOCK   = MAX_PARSE_BLOCK_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [INTERVAL_W-1:0] i_cfg_wdata,
    input  wire logic                  i_valid,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_ready,
    output t_push                      o_push
);

    localparam logic [7:0]  CH_NUL  = 8'h00;
    localparam logic [7:0]  CH_DQ   = 8'h22;
    localparam logic [7:0]  CH_SQ   = 8'h27;
    localparam logic [7:0]  CH_SEMI = 8'h3B;
    localparam logic [7:0]  CH_EQ   = 8'h3D;
    localparam logic [7:0]  CH_BSL  = 8'h5C;
    localparam logic [11:0] LEN_MAX = '1;

    typedef enum logic [1:0] {
        PH_AUDIO = 2'b01,
        PH_META  = 2'b10
    } t_phase;

    typedef enum logic [3:0] {
        TS_WAIT_EQ    = 4'b0001,
        TS_WAIT_QUOTE = 4'b0010,
        TS_IN_TITLE   = 4'b0100,
        TS_DONE       = 4'b1000
    } t_tstate;

    logic [INTERVAL_W-1:0] r_interval;
    logic [INTERVAL_W-1:0] r_count,  n_count;
    t_phase                r_phase,  n_phase;
    logic [11:0]           r_rem,    n_rem;
    logic [11:0]           r_off,    n_off;
    logic                  r_parse,  n_parse;
    t_tstate               r_tstate, n_tstate;
    logic                  r_dq,     n_dq;
    logic [7:0]            r_prev,   n_prev;
    logic                  r_qp,     n_qp;
    logic [11:0]           r_len,    n_len;
    logic                  r_halted, n_halted;

    logic       accept;
    logic       is_last;
    logic       emitted;
    logic       handled;
    logic [7:0] q_char;
    t_cmd       cmd;

    function automatic t_cmd put(input t_cmd c, input logic second,
                                 input t_kind k, input logic [7:0] d);
        t_cmd r;
        r = c;
        if (second) begin
            r.has1  = 1'b1;
            r.kind1 = k;
            r.byte1 = d;
        end else begin
            r.kind0 = k;
            r.byte0 = d;
        end
        return r;
    endfunction

    assign accept = i_valid && i_ready;
    assign q_char = r_dq ? CH_DQ : CH_SQ;

    always_comb begin
        n_count  = r_count;
        n_phase  = r_phase;
        n_rem    = r_rem;
        n_off    = r_off;
        n_parse  = r_parse;
        n_tstate = r_tstate;
        n_dq     = r_dq;
        n_prev   = r_prev;
        n_qp     = r_qp;
        n_len    = r_len;
        n_halted = r_halted;
        cmd      = '0;
        emitted  = 1'b0;
        handled  = 1'b0;
        is_last  = (r_rem <= 12'd1);

        if (accept && !r_halted) begin
            if (r_interval == '0) begin
                cmd     = put(cmd, emitted, K_AUDIO, i_byte);
                emitted = 1'b1;
            end else if (r_phase == PH_AUDIO) begin
                if (r_count >= r_interval) begin
                    n_count = '0;
                    // A zero length byte announces an empty block.
                    if (i_byte != CH_NUL) begin
                        n_rem    = {i_byte, 4'b0000};
                        n_off    = '0;
                        n_parse  = ({1'b0, i_byte, 4'b0000} < 13'(MAX_PARSE_BLOCK));
                        n_tstate = TS_WAIT_EQ;
                        n_dq     = 1'b0;
                        n_prev   = CH_NUL;
                        n_qp     = 1'b0;
                        n_len    = '0;
                        n_phase  = PH_META;
                    end
                end else begin
                    n_count = INTERVAL_W'(r_count + 1'b1);
                    cmd     = put(cmd, emitted, K_AUDIO, i_byte);
                    emitted = 1'b1;
                end
            end else begin
                n_off = 12'(r_off + 1'b1);
                n_rem = is_last ? 12'd0 : 12'(r_rem - 1'b1);
                if (is_last) begin
                    n_phase = PH_AUDIO;
                end
                if (r_parse && (r_off >= 12'(TITLE_PREFIX_SKIP))) begin
                    n_prev = i_byte;
                    case (r_tstate)
                        TS_WAIT_EQ: begin
                            if (i_byte == CH_EQ) begin
                                n_tstate = TS_WAIT_QUOTE;
                            end
                        end
                        TS_WAIT_QUOTE: begin
                            if (i_byte == CH_SQ) begin
                                n_dq     = 1'b0;
                                n_tstate = TS_IN_TITLE;
                            end else if (i_byte == CH_DQ) begin
                                n_dq     = 1'b1;
                                n_tstate = TS_IN_TITLE;
                            end
                        end
                        TS_IN_TITLE: begin
                            // A held quote is settled by the byte that follows it.
                            if (r_qp) begin
                                n_qp = 1'b0;
                                if (i_byte == CH_SEMI || i_byte == CH_NUL) begin
                                    cmd = put(cmd, emitted,
                                              (n_len >= 12'd2) ? K_DONE : K_SHORT, 8'h00);
                                    emitted  = 1'b1;
                                    n_tstate = TS_DONE;
                                    handled  = 1'b1;
                                end else begin
                                    cmd     = put(cmd, emitted, K_TITLE, q_char);
                                    emitted = 1'b1;
                                    if (n_len != LEN_MAX) begin
                                        n_len = 12'(n_len + 1'b1);
                                    end
                                end
                            end
                            if (!handled) begin
                                if (i_byte == CH_NUL) begin
                                    if (n_len >= 12'd2) begin
                                        cmd      = put(cmd, emitted, K_OVERLAP, 8'h00);
                                        n_halted = 1'b1;
                                    end else begin
                                        cmd = put(cmd, emitted, K_SHORT, 8'h00);
                                    end
                                    emitted  = 1'b1;
                                    n_tstate = TS_DONE;
                                end else if (i_byte == q_char && r_prev != CH_BSL) begin
                                    if (is_last) begin
                                        cmd = put(cmd, emitted,
                                                  (n_len >= 12'd2) ? K_DONE : K_SHORT,
                                                  8'h00);
                                        emitted  = 1'b1;
                                        n_tstate = TS_DONE;
                                    end else begin
                                        n_qp = 1'b1;
                                    end
                                end else if (is_last) begin
                                    cmd      = put(cmd, emitted, K_SHORT, 8'h00);
                                    emitted  = 1'b1;
                                    n_tstate = TS_DONE;
                                end else begin
                                    cmd     = put(cmd, emitted, K_TITLE, i_byte);
                                    emitted = 1'b1;
                                    if (n_len != LEN_MAX) begin
                                        n_len = 12'(n_len + 1'b1);
                                    end
                                end
                            end
                        end
                        TS_DONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    assign o_push.valid = emitted;
    assign o_push.cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= '0;
            r_count    <= '0;
            r_phase    <= PH_AUDIO;
            r_rem      <= '0;
            r_off      <= '0;
            r_parse    <= 1'b0;
            r_tstate   <= TS_WAIT_EQ;
            r_dq       <= 1'b0;
            r_prev     <= CH_NUL;
            r_qp       <= 1'b0;
            r_len      <= '0;
            r_halted   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            r_count  <= n_count;
            r_phase  <= n_phase;
            r_rem    <= n_rem;
            r_off    <= n_off;
            r_parse  <= n_parse;
            r_tstate <= n_tstate;
            r_dq     <= n_dq;
            r_prev   <= n_prev;
            r_qp     <= n_qp;
            r_len    <= n_len;
            r_halted <= n_halted;
        end
    end

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_push.valid)
        else $error("command issued while halted");

    a_pending_in_title: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qp |-> (r_tstate == TS_IN_TITLE) && (r_phase == PH_META))
        else $error("quote held outside a title");

endmodule
`default_nettype wire

// ----- rtl/core/imdf_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ICY metadata deframer command queue
// Small FIFO of commands that decouples the front end from the result
// sequencer.
// ----------------------------------------------------------------------------
module imdf_queue
    import imdf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_head_valid,
    output t_cmd       o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("command pushed into a full queue");

endmodule
`default_nettype wire

// ----- rtl/core/imdf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ICY metadata deframer result sequencer
// Takes the command at the head of the queue and delivers its one or two
// results on the output stream, marking the last one of each byte.
// ----------------------------------------------------------------------------
module imdf_back
    import imdf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_head_valid,
    input  wire t_cmd  i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [7:0] o_byte,
    output logic [2:0] o_kind,
    output logic       o_last
);

    logic r_second;
    logic take;

    assign o_valid = i_head_valid;
    assign o_kind  = r_second ? i_head.kind1 : i_head.kind0;
    assign o_byte  = r_second ? i_head.byte1 : i_head.byte0;
    assign o_last  = r_second || !i_head.has1;
    assign take    = i_head_valid && i_ready;
    assign o_pop   = take && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= !o_last;
        end
    end

    a_second_has_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> i_head_valid && i_head.has1)
        else $error("second result selected without a pair");

endmodule
`default_nettype wire

// ----- rtl/core/icy_metadata_deframer_top.sv -----
`default_nettype none
// A result is written into the command queue when its byte is accepted and
// is offered from the queue head; bytes with no result produce nothing.
// Bytes are accepted one per cycle while the command queue is not full; the
// classifier is combinational. A byte with two results leaves as two output
// transfers, which a four-entry command queue absorbs. Reset is synchronous,
// active low, clears all control state at once and needs no clearing pass.
// ----------------------------------------------------------------------------
// ICY metadata deframer top level
// Strips in-band metadata blocks from a stream and extracts the stream title.
// ----------------------------------------------------------------------------
module icy_metadata_deframer_top
    import imdf_pkg::*;
#(
    parameter int TITLE_PREFIX_SKIP = TITLE_PREFIX_SKIP_DEF,
    parameter int MAX_PARSE_BLOCK   = MAX_PARSE_BLOCK_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [INTERVAL_W-1:0] i_cfg_wdata,   // meta_interval
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] stream_byte
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [7:0] out_byte
    output logic [2:0]                 m_axis_tuser,  // [2:0] kind
    output logic                       m_axis_tlast
);

    t_push push;
    t_cmd  head;
    logic  full;
    logic  head_valid;
    logic  pop;

    assign s_axis_tready = !full;

    imdf_front #(
        .TITLE_PREFIX_SKIP (TITLE_PREFIX_SKIP),
        .MAX_PARSE_BLOCK   (MAX_PARSE_BLOCK)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .i_ready     (s_axis_tready),
        .o_push      (push)
    );

    imdf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    imdf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_kind       (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

endmodule
`default_nettype wire
